// ===== hdl/bdkr_pkg.sv =====
// ----------------------------------------------------------------------------
// bdkr_pkg
// Shared types and codes for the bounded deque with k-th read and reverse.
// ----------------------------------------------------------------------------
`default_nettype none

package bdkr_pkg;

    typedef enum logic [2:0] {
        OP_INS_BACK  = 3'd0,
        OP_INS_FRONT = 3'd1,
        OP_REM_FRONT = 3'd2,
        OP_REM_BACK  = 3'd3,
        OP_KTH_BACK  = 3'd4,
        OP_REVERSE   = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_WRITE      = 2'd1,
        CELL_SHIFT_UP   = 2'd2,
        CELL_SHIFT_DOWN = 2'd3
    } t_cell_cmd;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_PROBE = 1'b1
    } t_state;

    localparam int OUT_BITS = 32;
    localparam int IN_BITS  = 32;
    localparam int POS_BITS = 5;
    localparam int OCC_BITS = 5;

endpackage

`default_nettype wire

// ===== hdl/bdkr_cell.sv =====
// ----------------------------------------------------------------------------
// bdkr_cell
// One storage cell of the deque row. It holds one word, takes the new word on a
// write to its index, takes a neighbor's word on a shift, and passes the read probe on toward the high end.
// ----------------------------------------------------------------------------
`default_nettype none

module bdkr_cell
    import bdkr_pkg::*;
#(
    parameter int INDEX     = 0,
    parameter int IDX_BITS  = 4,
    parameter int WORD_BITS = 32
) (
    input  wire logic                 i_clk,
    input  wire t_cell_cmd            i_cmd,
    input  wire logic [IDX_BITS-1:0]  i_index,
    input  wire logic [IDX_BITS-1:0]  i_target,
    input  wire logic [WORD_BITS-1:0] i_word,
    input  wire logic [WORD_BITS-1:0] i_from_low,
    input  wire logic [WORD_BITS-1:0] i_from_high,
    input  wire logic [WORD_BITS-1:0] i_probe,
    output logic      [WORD_BITS-1:0] o_word,
    output logic      [WORD_BITS-1:0] o_probe
);

    logic [WORD_BITS-1:0] r_word;
    logic [WORD_BITS-1:0] n_word;
    logic [WORD_BITS-1:0] r_probe;
    logic [WORD_BITS-1:0] n_probe;

    always_comb begin
        unique case (i_cmd)
            CELL_HOLD:       n_word = r_word;
            CELL_WRITE:      n_word = (i_index == IDX_BITS'(INDEX)) ? i_word : r_word;
            CELL_SHIFT_UP:   n_word = i_from_low;
            CELL_SHIFT_DOWN: n_word = i_from_high;
            default:         n_word = r_word;
        endcase
        n_probe = (i_target == IDX_BITS'(INDEX)) ? r_word : i_probe;
    end

    always_ff @(posedge i_clk) begin
        r_word  <= n_word;
        r_probe <= n_probe;
    end

    assign o_word  = r_word;
    assign o_probe = r_probe;

endmodule

`default_nettype wire

// ===== hdl/bounded_deque_kth_reverse_core.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_kth_reverse_core
// Bounded double-ended queue of signed words with k-th-from-back read and
// constant-time reverse, built as a row of storage cells.
// ----------------------------------------------------------------------------
// The words sit in a row of DEPTH cells in order from the low end, and a
// direction flag decides which end is the front. Inserts, removals at the low
// end, reverse and every request that ends in an error are decided at the
// edge that accepts them, and when the output is free the result is on the
// output from the next edge. The input is stalled after each such request until
// its result has left the holding register.
// A read of the k-th element and a removal at the high end send a probe along
// the cell row, one cell per cycle; when the probe has passed the last cell, the
// result goes into the holding register and then to the output, and the input
// is stalled while the probe runs.
// One finished result can wait in a holding register while another sits on
// the output, so a stalled output does not stop the next request at once.
`default_nettype none

module bounded_deque_kth_reverse_core
    import bdkr_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [2:0]                 i_operation,
    input  wire logic signed [IN_BITS-1:0]  i_value,
    input  wire logic [POS_BITS-1:0]        i_position,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic signed [OUT_BITS-1:0]      o_result_value,
    output logic [1:0]                      o_status,
    output logic [OCC_BITS-1:0]             o_occupancy
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = (CW > POS_BITS) ? CW : POS_BITS;

    function automatic logic [OUT_BITS-1:0] widen(input logic [WORD_BITS-1:0] w);
        logic [63:0] s;
        s = 64'(signed'(w));
        return s[OUT_BITS-1:0];
    endfunction

    t_state               r_state;
    t_state               n_state;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic                 r_rev;
    logic                 n_rev;
    logic [IW-1:0]        r_target;
    logic [IW-1:0]        n_target;
    logic                 r_take;
    logic                 n_take;
    logic [CW-1:0]        r_pcnt;
    logic [CW-1:0]        n_pcnt;

    logic                 r_hold_valid;
    logic                 n_hold_valid;
    logic [OUT_BITS-1:0]  r_hold_value;
    logic [OUT_BITS-1:0]  n_hold_value;
    t_status              r_hold_status;
    t_status              n_hold_status;
    logic [OCC_BITS-1:0]  r_hold_occ;
    logic [OCC_BITS-1:0]  n_hold_occ;

    logic                 r_out_valid;
    logic                 n_out_valid;
    logic [OUT_BITS-1:0]  r_out_value;
    t_status              r_out_status;
    logic [OCC_BITS-1:0]  r_out_occ;

    logic                 w_accept;
    logic                 w_move;
    logic                 w_start_probe;
    logic                 w_finish;
    t_op                  w_op;
    logic [63:0]          w_value_ext;
    logic [WORD_BITS-1:0] w_new_word;
    logic                 w_full;
    logic                 w_empty;
    logic [KW-1:0]        w_kx;
    logic [KW-1:0]        w_cx;
    logic [KW-1:0]        w_koff;
    t_cell_cmd            w_cmd;

    logic [WORD_BITS-1:0] w_word  [DEPTH];
    logic [WORD_BITS-1:0] w_probe [DEPTH];

    assign w_op        = t_op'(i_operation);
    assign w_value_ext = {32'd0, i_value};
    assign w_new_word  = w_value_ext[WORD_BITS-1:0];
    assign w_full      = (r_count == CW'(DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_kx        = KW'(i_position);
    assign w_cx        = KW'(r_count);
    assign w_koff      = r_rev ? (w_kx - KW'(1)) : (w_cx - w_kx);
    assign w_finish    = (r_state == S_PROBE) && (r_pcnt == CW'(DEPTH));
    assign w_accept    = i_valid && !o_stall;
    assign w_move      = r_hold_valid && (!r_out_valid || !i_stall);

    // Request decode and result capture.
    always_comb begin
        n_count       = r_count;
        n_rev         = r_rev;
        n_target      = r_target;
        n_take        = r_take;
        n_pcnt        = (r_state == S_PROBE) ? r_pcnt + CW'(1) : '0;
        w_cmd         = CELL_HOLD;
        w_start_probe = 1'b0;
        n_hold_valid  = w_move ? 1'b0 : r_hold_valid;
        n_hold_value  = r_hold_value;
        n_hold_status = r_hold_status;
        n_hold_occ    = r_hold_occ;
        if (w_accept) begin
            n_hold_value  = '0;
            n_hold_status = ST_OK;
            unique case (w_op)
                OP_INS_BACK, OP_INS_FRONT: begin
                    if (w_full) begin
                        n_hold_status = ST_FULL;
                    end else begin
                        n_count = r_count + CW'(1);
                        w_cmd   = ((w_op == OP_INS_BACK) != r_rev) ? CELL_WRITE
                                                                   : CELL_SHIFT_UP;
                    end
                end
                OP_REM_FRONT, OP_REM_BACK: begin
                    if (w_empty) begin
                        n_hold_status = ST_EMPTY;
                    end else if ((w_op == OP_REM_BACK) != r_rev) begin
                        w_start_probe = 1'b1;
                        n_take        = 1'b1;
                        n_target      = IW'(r_count - CW'(1));
                    end else begin
                        n_hold_value = widen(w_word[0]);
                        n_count      = r_count - CW'(1);
                        w_cmd        = CELL_SHIFT_DOWN;
                    end
                end
                OP_KTH_BACK: begin
                    if (w_empty) begin
                        n_hold_status = ST_EMPTY;
                    end else if (i_position == '0 || w_kx > w_cx) begin
                        n_hold_status = ST_RANGE;
                    end else begin
                        w_start_probe = 1'b1;
                        n_take        = 1'b0;
                        n_target      = IW'(w_koff);
                    end
                end
                OP_REVERSE: begin
                    if (!w_empty) begin
                        n_rev = !r_rev;
                    end
                end
                default: begin
                end
            endcase
            n_hold_occ   = OCC_BITS'(n_count);
            n_hold_valid = !w_start_probe;
        end else if (w_finish) begin
            n_hold_value  = widen(w_probe[DEPTH-1]);
            n_hold_status = ST_OK;
            if (r_take) begin
                n_count = r_count - CW'(1);
            end
            n_hold_occ   = OCC_BITS'(n_count);
            n_hold_valid = 1'b1;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept && w_start_probe) n_state = S_PROBE;
            S_PROBE: if (w_finish) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        unique case (r_state)
            S_IDLE:  o_stall = r_hold_valid;
            S_PROBE: o_stall = 1'b1;
            default: o_stall = 1'b1;
        endcase
    end

    assign n_out_valid = w_move ? 1'b1 : (r_out_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_rev        <= 1'b0;
            r_take       <= 1'b0;
            r_pcnt       <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_rev        <= n_rev;
            r_take       <= n_take;
            r_pcnt       <= n_pcnt;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_target      <= n_target;
        r_hold_value  <= n_hold_value;
        r_hold_status <= n_hold_status;
        r_hold_occ    <= n_hold_occ;
        if (w_move) begin
            r_out_value  <= r_hold_value;
            r_out_status <= r_hold_status;
            r_out_occ    <= r_hold_occ;
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        bdkr_cell #(
            .INDEX     (g),
            .IDX_BITS  (IW),
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_cmd       (w_cmd),
            .i_index     (r_count[IW-1:0]),
            .i_target    (r_target),
            .i_word      (w_new_word),
            .i_from_low  ((g == 0) ? w_new_word : w_word[(g == 0) ? 0 : g - 1]),
            .i_from_high ((g == DEPTH - 1) ? '0 : w_word[(g == DEPTH - 1) ? g : g + 1]),
            .i_probe     ((g == 0) ? '0 : w_probe[(g == 0) ? 0 : g - 1]),
            .o_word      (w_word[g]),
            .o_probe     (w_probe[g])
        );
    end

    assign o_valid        = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_status       = r_out_status;
    assign o_occupancy    = r_out_occ;

endmodule

`default_nettype wire

// ===== hdl/bdkr_checker.sv =====
// ----------------------------------------------------------------------------
// bdkr_checker
// Port-level checks on the deque core's results, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bdkr_checker
    import bdkr_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      o_valid,
    input wire logic                      i_stall,
    input wire logic signed [OUT_BITS-1:0] o_result_value,
    input wire logic [1:0]                o_status,
    input wire logic [OCC_BITS-1:0]       o_occupancy
);

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |-> o_result_value == '0)
        else $error("Failed request returned a nonzero word.");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_FULL) |-> o_occupancy == OCC_BITS'(DEPTH))
        else $error("Full status with a queue that is not full.");

    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_EMPTY) |-> o_occupancy == '0)
        else $error("Empty status with a queue that is not empty.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_value) && $stable(o_status))
        else $error("Stalled result changed.");

endmodule

bind bounded_deque_kth_reverse_core bdkr_checker #(
    .DEPTH (DEPTH)
) u_bdkr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_result_value (o_result_value),
    .o_status       (o_status),
    .o_occupancy    (o_occupancy)
);

`default_nettype wire
